// ----- src/fdl_pkg.sv -----
// shared types, constants and helper functions of the feedback delay line
package fdl_pkg;

    // store geometry
    localparam int MAX_LEN   = 8192;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int TAP_COUNT = 4;
    localparam int TAP_W     = $clog2(TAP_COUNT);
    localparam int CNT_W     = $clog2(ADDR_W);

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int COEF_W   = 16;
    localparam int WET_W    = 18;
    localparam int PROD_W   = WET_W + COEF_W + 1;
    localparam int SAT_IN_W = PROD_W + 1 - 15;

    // register limits and reset values
    localparam logic [LEN_W-1:0]  LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(4410);
    localparam logic [14:0]       FB_LIMIT  = 15'd32440;
    localparam logic [14:0]       FB_RESET  = 15'd16384;
    localparam logic [15:0]       WM_LIMIT  = 16'd32768;
    localparam logic [15:0]       WM_RESET  = 16'd16384;
    localparam logic [16:0]       Q15_ONE   = 17'd32768;

    // register indexes
    localparam logic [1:0] CFG_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_FEEDBACK = 2'd1;
    localparam logic [1:0] CFG_WET_MIX  = 2'd2;
    localparam logic [1:0] CFG_MODE     = 2'd3;

    // delay modes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_PINGPONG = 2'd1;
    localparam logic [1:0] MODE_MULTI    = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_WRAP,
        S_IDLE,
        S_TAP,
        S_FB,
        S_DRY,
        S_WET,
        S_MIX
    } state_t;

    typedef enum logic [1:0] {
        MUL_TAP,
        MUL_FB,
        MUL_DRY,
        MUL_WET
    } mul_sel_t;

    typedef struct packed {
        logic             accept;
        logic             clr_en;
        logic             wrap_step;
        logic             wrap_first;
        logic             wrap_load;
        logic [CNT_W-1:0] wrap_bit;
        logic             rd_en;
        logic [TAP_W-1:0] rd_tap;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic [TAP_W-1:0] mul_tap;
        logic             acc_en;
        logic             store_en;
        logic             mix_en;
        logic             out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic len_wr;
        logic multi;
        logic clr_done;
    } dp_status_t;

    // q15 tap weights 1, 1/2, 1/3, 1/4
    function automatic logic [COEF_W-1:0] tap_weight(input logic [TAP_W-1:0] t);
        logic [COEF_W-1:0] w;
        case (t)
            2'd0:    w = 16'd32768;
            2'd1:    w = 16'd16384;
            2'd2:    w = 16'd10923;
            2'd3:    w = 16'd8192;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_IN_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -SAT_IN_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/feedback_delay_line_multimode.sv -----
// top level of the multimode feedback delay line: stream ports, control and datapath
// per sample: tap, feedback, dry, wet and mix states, one tap read or four in four-tap mode;
//   one sample at a time, s_tready low until the result is loaded; set by the single read
//   port of the sample store and the one shared multiplier
// reset: a clearing pass zeroes all 8192 store entries, s_tready low until it is done;
//   a length write runs the position wrap, then below 8192 clears from the length to the top
module feedback_delay_line_multimode (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] audio_in
    input  logic        s_tuser,    // [0] block_start
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] audio_out
);
    import fdl_pkg::*;

    // command and status between the state machine and the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: clearing pass, position wrap after a length change, and the
    // per-sample schedule of tap reads, multiplies and the output transaction
    fdl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // registers, sample store, tap addressing and arithmetic; the output
    // register holds a finished sample while the next transaction is taken
    fdl_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule

// ----- src/fdl_ctrl.sv -----
// sequencing state machine: clearing pass, position wrap and per-sample schedule
module fdl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                m_tready,
    input  fdl_pkg::dp_status_t status,
    output logic                s_tready,
    output logic                m_tvalid,
    output fdl_pkg::ctrl_cmd_t  cmd
);
    import fdl_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    logic [CNT_W-1:0] n_taps;
    logic             ready;
    logic             out_free;

    assign n_taps   = status.multi ? CNT_W'(TAP_COUNT) : CNT_W'(1);
    assign ready    = (state_reg == S_IDLE) && !status.len_wr;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_CLEAR: begin
                if (status.len_wr) begin
                    state_next = S_WRAP;
                    cnt_next   = '0;
                end else if (status.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_WRAP: begin
                if (cnt_reg == CNT_W'(ADDR_W - 1)) begin
                    cnt_next  = '0;
                    pend_next = 1'b0;
                    if (pend_reg || status.len_wr) begin
                        state_next = S_WRAP;
                    end else if (status.clr_done) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_CLEAR;
                    end
                end else begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = pend_reg || status.len_wr;
                end
            end
            S_IDLE: begin
                cnt_next = '0;
                if (status.len_wr) begin
                    state_next = S_WRAP;
                end else if (s_tvalid) begin
                    state_next = S_TAP;
                end
            end
            S_TAP: begin
                if (cnt_reg == n_taps + CNT_W'(1)) begin
                    state_next = S_FB;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FB:  state_next = S_DRY;
            S_DRY: state_next = S_WET;
            S_WET: state_next = S_MIX;
            S_MIX: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        cmd        = '0;
        cmd.mul_sel = MUL_TAP;
        s_tready   = ready;
        case (state_reg)
            S_CLEAR: cmd.clr_en = !status.clr_done;
            S_WRAP: begin
                cmd.wrap_step  = 1'b1;
                cmd.wrap_first = (cnt_reg == '0);
                cmd.wrap_load  = (cnt_reg == CNT_W'(ADDR_W - 1));
                cmd.wrap_bit   = CNT_W'(ADDR_W - 1) - cnt_reg;
            end
            S_IDLE: cmd.accept = ready && s_tvalid;
            S_TAP: begin
                // read tap n, weight tap n-1, accumulate tap n-2
                cmd.rd_en   = (cnt_reg < n_taps);
                cmd.rd_tap  = cnt_reg[TAP_W-1:0];
                cmd.mul_en  = (cnt_reg >= CNT_W'(1)) && (cnt_reg <= n_taps);
                cmd.mul_sel = MUL_TAP;
                cmd.mul_tap = TAP_W'(cnt_reg - CNT_W'(1));
                cmd.acc_en  = (cnt_reg >= CNT_W'(2));
            end
            S_FB: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FB;
            end
            S_DRY: begin
                cmd.store_en = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DRY;
            end
            S_WET: begin
                cmd.mix_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WET;
            end
            S_MIX: cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- src/fdl_datapath.sv -----
// registers, sample store, tap addressing, shared multiplier and output register
module fdl_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic [15:0]        s_tdata,
    input  logic               s_tuser,
    input  fdl_pkg::ctrl_cmd_t cmd,
    output fdl_pkg::dp_status_t status,
    output logic [15:0]        out_data
);
    import fdl_pkg::*;

    logic [SAMPLE_W-1:0] mem [MAX_LEN];

    // control state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [14:0]       fb_reg, fb_next;
    logic [15:0]       wm_reg, wm_next;
    logic [1:0]        mode_reg, mode_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              odd_reg, odd_next;
    logic [LEN_W-1:0]  clr_ptr_reg, clr_ptr_next;

    // payload
    logic [ADDR_W-1:0]          rem_reg;
    logic [LEN_W-1:0]           div_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [WET_W-1:0]    wet_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   mix_reg;
    logic [SAMPLE_W-1:0]        out_reg;

    logic             len_wr;
    logic [LEN_W-1:0] len_clamp;
    logic [LEN_W-1:0] clr_adv;

    logic [ADDR_W-1:0] dly;
    logic [ADDR_W+1:0] dly3;
    logic [ADDR_W-1:0] tap_d;
    logic [ADDR_W+1:0] rd_sum;
    logic [ADDR_W-1:0] rd_addr;

    logic [ADDR_W-1:0] rem_cur;
    logic [LEN_W-1:0]  div_cur;
    logic [LEN_W-1:0]  rem_shift;
    logic [ADDR_W-1:0] rem_next;

    logic [LEN_W-1:0]  wp_inc;
    logic [ADDR_W-1:0] wp_adv;

    logic signed [WET_W-1:0]    mul_a;
    logic [COEF_W-1:0]          mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAT_IN_W-1:0] st_sum;
    logic signed [SAMPLE_W-1:0] st_val;
    logic signed [PROD_W:0]     mix_sum;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    logic [SAMPLE_W-1:0] mem_wd;

    // register writes with clamping
    assign len_wr = cfg_we && (cfg_index == CFG_LENGTH);

    always_comb begin
        if (cfg_wdata[LEN_W-1:0] < LEN_MIN) begin
            len_clamp = LEN_MIN;
        end else if (cfg_wdata[LEN_W-1:0] > LEN_MAX) begin
            len_clamp = LEN_MAX;
        end else begin
            len_clamp = cfg_wdata[LEN_W-1:0];
        end
    end

    always_comb begin
        len_next  = len_reg;
        fb_next   = fb_reg;
        wm_next   = wm_reg;
        mode_next = mode_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_LENGTH: len_next = len_clamp;
                CFG_FEEDBACK: begin
                    fb_next = (cfg_wdata[14:0] > FB_LIMIT) ? FB_LIMIT : cfg_wdata[14:0];
                end
                CFG_WET_MIX: begin
                    wm_next = (cfg_wdata > WM_LIMIT) ? WM_LIMIT : cfg_wdata;
                end
                CFG_MODE: begin
                    if (cfg_wdata[1:0] != 2'd3) begin
                        mode_next = cfg_wdata[1:0];
                    end
                end
                default: len_next = len_reg;
            endcase
        end
    end

    // clearing pointer: entries from it up to the top still need clearing
    always_comb begin
        clr_adv      = cmd.clr_en ? clr_ptr_reg + LEN_W'(1) : clr_ptr_reg;
        clr_ptr_next = clr_adv;
        if (len_wr && (len_clamp < clr_adv)) begin
            clr_ptr_next = len_clamp;
        end
    end

    // tap delay and store address
    assign dly  = ADDR_W'(len_reg - LEN_W'(1));
    assign dly3 = {2'b00, dly} + {1'b0, dly, 1'b0};

    always_comb begin
        tap_d = dly;
        case (mode_reg)
            MODE_NORMAL:   tap_d = dly;
            MODE_PINGPONG: tap_d = odd_reg ? dly : (dly >> 1);
            MODE_MULTI: begin
                case (cmd.rd_tap)
                    2'd0:    tap_d = dly >> 2;
                    2'd1:    tap_d = dly >> 1;
                    2'd2:    tap_d = dly3[ADDR_W+1:2];
                    default: tap_d = dly;
                endcase
                if (tap_d == '0) begin
                    tap_d = ADDR_W'(1);
                end
            end
            default: tap_d = dly;
        endcase
    end

    always_comb begin
        rd_sum = {2'b00, wp_reg} + {1'b0, len_reg} - {2'b00, tap_d};
        if (rd_sum >= {1'b0, len_reg}) begin
            rd_addr = ADDR_W'(rd_sum - {1'b0, len_reg});
        end else begin
            rd_addr = rd_sum[ADDR_W-1:0];
        end
    end

    // bit-serial remainder of the write position by a new length
    assign rem_cur   = cmd.wrap_first ? '0 : rem_reg;
    assign div_cur   = cmd.wrap_first ? len_reg : div_reg;
    assign rem_shift = {rem_cur, wp_reg[cmd.wrap_bit]};
    assign rem_next  = (rem_shift >= div_cur) ? ADDR_W'(rem_shift - div_cur)
                                              : rem_shift[ADDR_W-1:0];

    assign wp_inc = {1'b0, wp_reg} + LEN_W'(1);
    assign wp_adv = (wp_inc == len_reg) ? '0 : wp_inc[ADDR_W-1:0];

    always_comb begin
        wp_next = wp_reg;
        if (cmd.wrap_step && cmd.wrap_load) begin
            wp_next = rem_next;
        end else if (cmd.store_en) begin
            wp_next = wp_adv;
        end
    end

    always_comb begin
        odd_next = odd_reg;
        if (cmd.accept && s_tuser) begin
            odd_next = 1'b0;
        end else if (cmd.out_load) begin
            odd_next = ~odd_reg;
        end
    end

    // shared multiplier
    always_comb begin
        case (cmd.mul_sel)
            MUL_TAP: begin
                mul_a = WET_W'(rdata_reg);
                mul_b = tap_weight(cmd.mul_tap);
            end
            MUL_FB: begin
                mul_a = wet_reg;
                mul_b = {1'b0, fb_reg};
            end
            MUL_DRY: begin
                mul_a = WET_W'(x_reg);
                mul_b = COEF_W'(Q15_ONE - {1'b0, wm_reg});
            end
            MUL_WET: begin
                mul_a = wet_reg;
                mul_b = wm_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * $signed({1'b0, mul_b});

    // stored value and mixed output, floored products
    assign st_sum  = SAT_IN_W'(x_reg) + SAT_IN_W'($signed(prod_reg[PROD_W-1:15]));
    assign st_val  = sat16(st_sum);
    assign mix_sum = {mix_reg[PROD_W-1], mix_reg} + {prod_reg[PROD_W-1], prod_reg};

    assign mem_we = cmd.clr_en || cmd.store_en;
    assign mem_wa = cmd.clr_en ? clr_ptr_reg[ADDR_W-1:0] : wp_reg;
    assign mem_wd = cmd.clr_en ? '0 : st_val;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_RESET;
            fb_reg      <= FB_RESET;
            wm_reg      <= WM_RESET;
            mode_reg    <= MODE_NORMAL;
            wp_reg      <= '0;
            odd_reg     <= 1'b0;
            clr_ptr_reg <= '0;
        end else begin
            len_reg     <= len_next;
            fb_reg      <= fb_next;
            wm_reg      <= wm_next;
            mode_reg    <= mode_next;
            wp_reg      <= wp_next;
            odd_reg     <= odd_next;
            clr_ptr_reg <= clr_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wrap_step) begin
            rem_reg <= rem_next;
            div_reg <= div_cur;
        end
        if (cmd.accept) begin
            x_reg   <= $signed(s_tdata);
            wet_reg <= '0;
        end else if (cmd.acc_en) begin
            wet_reg <= wet_reg + $signed(prod_reg[WET_W+14:15]);
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.mix_en) begin
            mix_reg <= prod_reg;
        end
        if (cmd.out_load) begin
            out_reg <= sat16(mix_sum[PROD_W:15]);
        end
    end

    assign status.len_wr   = len_wr;
    assign status.multi    = (mode_reg == MODE_MULTI);
    assign status.clr_done = (clr_ptr_reg == LEN_MAX);
    assign out_data        = out_reg;

endmodule

// ----- bench/feedback_delay_line_multimode_tb.sv -----
// self-checking bench for the multimode feedback delay line: stream driver, scoreboard, echo predictor
module feedback_delay_line_multimode_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] sample;
        logic        block_start;
    } echo_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_LENGTH;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // [15:0] audio_in
    logic        s_tuser   = 1'b0;  // [0] block_start
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [15:0] audio_out

    feedback_delay_line_multimode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // bench-side copy of the echo state and registers
    bit signed [15:0] echo_store [MAX_LEN];
    int               wr_pos    = 0;
    bit               odd_phase = 1'b0;
    int               buf_len   = int'(LEN_RESET);
    longint           fb_gain   = longint'(FB_RESET);
    longint           wet_share = longint'(WM_RESET);
    logic [1:0]       mode_reg  = MODE_NORMAL;
    int               tap_gain [TAP_COUNT] = '{32768, 16384, 10923, 8192};

    echo_item_t  pending_samples [$];
    logic [15:0] echo_expected [$];
    echo_item_t  next_item;
    bit          calm           = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          hold_left      = 0;
    int          granted        = 0;

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint tap_fetch(input int d);
        int pick;
        if (d > buf_len - 1) d = buf_len - 1;
        pick = (wr_pos + buf_len - d) % buf_len;
        return longint'(echo_store[pick]);
    endfunction

    function automatic void reg_apply(input logic [1:0] idx, input logic [15:0] val);
        int i;
        case (idx)
            CFG_LENGTH: begin
                buf_len = int'(val[13:0]);
                if (buf_len < int'(LEN_MIN)) buf_len = int'(LEN_MIN);
                if (buf_len > int'(LEN_MAX)) buf_len = int'(LEN_MAX);
                wr_pos = wr_pos % buf_len;
                // entries past the new end read back as zero if the store grows again
                for (i = buf_len; i < MAX_LEN; i++) echo_store[i] = '0;
            end
            CFG_FEEDBACK: fb_gain = longint'((val[14:0] > FB_LIMIT) ? FB_LIMIT : val[14:0]);
            CFG_WET_MIX:  wet_share = longint'((val > WM_LIMIT) ? WM_LIMIT : val);
            CFG_MODE: begin
                // the unused mode code leaves the register as it was
                if (val[1:0] <= MODE_MULTI) mode_reg = val[1:0];
            end
            default: ;
        endcase
    endfunction

    // one sample through the echo: returns audio_out and advances the store
    function automatic logic [15:0] echo_predict(input logic [15:0] raw, input logic blk);
        longint x, wet, fed;
        int     dly, d, t;
        x   = longint'($signed(raw));
        dly = buf_len - 1;
        if (blk) odd_phase = 1'b0;
        case (mode_reg)
            MODE_NORMAL:   wet = tap_fetch(dly);
            MODE_PINGPONG: wet = odd_phase ? tap_fetch(dly) : tap_fetch(dly / 2);
            default: begin
                wet = 0;
                for (t = 1; t <= TAP_COUNT; t++) begin
                    d = dly * t / TAP_COUNT;
                    if (d < 1) d = 1;
                    wet += (tap_fetch(d) * tap_gain[t-1]) >>> 15;
                end
            end
        endcase
        fed = longint'($signed(clip16(x + ((wet * fb_gain) >>> 15))));
        echo_store[wr_pos] = 16'(fed);
        wr_pos    = (wr_pos + 1) % buf_len;
        odd_phase = ~odd_phase;
        return clip16((x * (32768 - wet_share) + wet * wet_share) >>> 15);
    endfunction

    task automatic push_sample(input logic [15:0] smp, input logic blk);
        echo_item_t it;
        it.sample      = smp;
        it.block_start = blk;
        pending_samples.push_back(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        reg_apply(idx, val);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sender pauses until every outstanding result is back, then a short settle
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || echo_expected.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // input driver: one transaction per handshake, random gaps unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) echo_expected.push_back(echo_predict(s_tdata, s_tuser));
            if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
                next_item = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.sample;
                s_tuser  <= next_item.block_start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready: random stalls plus two long hold-offs so the block backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) granted++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready && (granted == 300 || granted == 1100)) begin
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // result checker against the oldest predicted sample
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (echo_expected.size() == 0) begin
                $display("%0t: unexpected audio_out %0d, expected nothing",
                         $time, $signed(m_tdata));
                mismatch_count++;
            end else if (m_tdata !== echo_expected[0]) begin
                $display("%0t: audio_out expected %0d, actual %0d",
                         $time, $signed(echo_expected[0]), $signed(m_tdata));
                mismatch_count++;
                void'(echo_expected.pop_front());
            end else begin
                void'(echo_expected.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("feedback_delay_line_multimode verification failed");
            $finish;
        end
    end

    initial begin
        int          issued;
        int          phase;
        int          count;
        int          k;
        logic [15:0] len_val;
        logic [15:0] fb_val;
        logic [15:0] wm_val;

        // reset settings, normal mode: full-scale, zero and minus-one samples against an empty store
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hffff, 1'b0);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // ping-pong at the shortest store: zero half delay, feedback and mix over limit
        write_reg(CFG_FEEDBACK, 16'hffff);
        write_reg(CFG_WET_MIX, 16'hffff);
        write_reg(CFG_MODE, 16'(MODE_PINGPONG));
        write_reg(CFG_LENGTH, 16'd1);
        push_sample(16'h7fff, 1'b1);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h3039, 1'b0);
        push_sample(16'h0001, 1'b0);
        wait_drained();

        // unused mode code ignored; length with upper data bits set
        write_reg(CFG_MODE, 16'hfffb);
        write_reg(CFG_LENGTH, 16'hc003);
        for (k = 0; k < 5; k++) push_sample(k[0] ? 16'h8000 : 16'h7fff, k == 3);
        wait_drained();

        // four taps, no feedback, fully wet
        write_reg(CFG_MODE, 16'(MODE_MULTI));
        write_reg(CFG_FEEDBACK, 16'd0);
        write_reg(CFG_LENGTH, 16'd5);
        for (k = 0; k < 6; k++) push_sample(k < 3 ? 16'h7fff : 16'h8000, 1'b0);
        wait_drained();

        // length above the maximum: store grows, new entries read as zero
        write_reg(CFG_MODE, 16'(MODE_NORMAL));
        write_reg(CFG_LENGTH, 16'h3fff);
        push_sample(16'h1234, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7fff, 1'b0);
        wait_drained();

        // random phases, length written last so it is the only write that triggers a clear
        issued = 0;
        phase  = 0;
        while (issued < 1600) begin
            calm = (phase == 2);
            case ($urandom_range(0, 7))
                0:       fb_val = 16'd0;
                1:       fb_val = 16'(FB_LIMIT);
                2:       fb_val = 16'($urandom);
                default: fb_val = 16'($urandom_range(0, 32440));
            endcase
            case ($urandom_range(0, 7))
                0:       wm_val = 16'd0;
                1:       wm_val = WM_LIMIT;
                2:       wm_val = 16'($urandom);
                default: wm_val = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 15))
                0:       len_val = 16'd2;
                1:       len_val = 16'd1;
                2, 3:    len_val = 16'($urandom_range(41, 600));
                4:       len_val = 16'($urandom);
                5:       len_val = 16'(MAX_LEN);
                default: len_val = 16'($urandom_range(2, 40));
            endcase
            if ($urandom_range(0, 3) != 0) write_reg(CFG_FEEDBACK, fb_val);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_WET_MIX, wm_val);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_MODE, 16'($urandom));
            write_reg(CFG_LENGTH, len_val);

            count = $urandom_range(60, 160);
            for (k = 0; k < count; k++)
                push_sample(random_sample(), $urandom_range(0, 9) == 0);
            issued += count;
            wait_drained();
            phase++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (24) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("feedback_delay_line_multimode verification clean");
        end else begin
            $display("feedback_delay_line_multimode verification failed");
        end
        $finish;
    end

endmodule
